### src/mfq_pkg.sv
package mfq_pkg;

  localparam int unsigned MAX_PROCS_DEFAULT = 64;
  localparam int unsigned LEVELS_DEFAULT    = 10;

  localparam int unsigned PID_W      = 6;
  localparam int unsigned LVL_W      = 4;
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned QUANT_W    = 10;
  localparam int unsigned BASE_W     = 8;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_QUANTUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_STEP = 1'b1;

  localparam logic [BASE_W-1:0] BASE_QUANTUM_RST = 8'd5;
  localparam logic [STEP_W-1:0] QUANTUM_STEP_RST = 5'd3;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_DISPATCH = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [PID_W-1:0]     process_id;
    logic                 first_run;
    logic [BURST_W-1:0]   last_burst;
    logic                 requeue_running;
  } in_t;

  typedef struct packed {
    logic                 dispatched_valid;
    logic [PID_W-1:0]     out_process;
    logic [LVL_W-1:0]     out_level;
    logic [QUANT_W-1:0]   out_quantum;
    logic                 appended;
  } out_t;

endpackage

### src/mfq_ram.sv
module mfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while no read is issued. A read that hits the entry
  // being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/multilevel_feedback_queue_scheduler_top.sv
// Channel  Direction  Handshake                  Beat
// cfg      in         cfg_we_i                   cfg_idx_i, cfg_data_i
// in       in         in_valid_i / in_stall_o    in_data_i  (mfq_pkg::in_t)
// out      out        out_valid_o / out_stall_i  out_data_o (mfq_pkg::out_t)
//
// An insert goes through the adjust step to its result beat, a dispatch also
// through the pop step, as the link memory and the per-process memory (queued
// mark and level) are read with registered outputs; the latter is read, modified
// and written back once for the adjusted process and once for the popped one.
// After reset a clearing pass over every entry zeroes the per-process memory;
// in_stall_o stays high during it, configuration writes are taken as ever.
// A beat that waits in the result register does not block acceptance; the
// step that produces the next result waits until the register is free.
module multilevel_feedback_queue_scheduler_top #(
  parameter int unsigned MAX_PROCS = mfq_pkg::MAX_PROCS_DEFAULT,
  parameter int unsigned LEVELS    = mfq_pkg::LEVELS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mfq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mfq_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mfq_pkg::out_t                   out_data_o
);

  import mfq_pkg::*;

  // Width of a process index and of a level index into the per-level state.
  localparam int unsigned PW   = $clog2(MAX_PROCS);
  localparam int unsigned LIW  = $clog2(LEVELS);
  // Per-process entry: queued mark above the level.
  localparam int unsigned PE_W = 1 + LVL_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_ADJ  = 2'd2;
  localparam logic [1:0] ST_POP  = 2'd3;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);
  localparam logic [PW-1:0]    PROC_LAST = PW'(MAX_PROCS - 1);

  // Control registers.
  logic [1:0]          state_q, state_d;
  logic [PW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [BASE_W-1:0]   base_q, base_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [PW-1:0]       run_proc_q, run_proc_d;
  logic                run_valid_q, run_valid_d;
  logic [LEVELS-1:0]   nonempty_q, nonempty_d;
  logic                out_valid_q, out_valid_d;

  // Payload registers.
  in_t                 item_q, item_d;
  logic [PW-1:0]       adj_proc_q, adj_proc_d;
  logic                do_adj_q, do_adj_d;
  logic [PW-1:0]       head_q [LEVELS];
  logic [PW-1:0]       head_d [LEVELS];
  logic [PW-1:0]       tail_q [LEVELS];
  logic [PW-1:0]       tail_d [LEVELS];
  logic                pop_any_q, pop_any_d;
  logic [LIW-1:0]      pop_lvl_q, pop_lvl_d;
  logic [PW-1:0]       pop_proc_q, pop_proc_d;
  logic                app_q, app_d;
  out_t                out_q, out_d;
  logic                pe_fwd_hit_q, pe_fwd_hit_d;
  logic [PE_W-1:0]     pe_fwd_data_q, pe_fwd_data_d;
  logic                nx_fwd_hit_q, nx_fwd_hit_d;
  logic [PW-1:0]       nx_fwd_data_q, nx_fwd_data_d;

  // Memory ports.
  logic                pe_we, pe_re;
  logic [PW-1:0]       pe_waddr, pe_raddr;
  logic [PE_W-1:0]     pe_wdata, pe_rdata;
  logic                nx_we, nx_re;
  logic [PW-1:0]       nx_waddr, nx_raddr;
  logic [PW-1:0]       nx_wdata, nx_rdata;

  // Datapath.
  logic                accept;
  logic                res_free;
  logic                pid_ok;
  logic [PW-1:0]       pid_idx;
  logic [PE_W-1:0]     pe_cur;
  logic [PW-1:0]       nx_cur;
  logic                queued_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [BASE_W:0]     prod_lvl;
  logic [QUANT_W-1:0]  q_cur;
  logic [BURST_W+2:0]  burst_x5;
  logic [QUANT_W+1:0]  q_x4;
  logic                go_up, go_down;
  logic                first_eff;
  logic [LVL_W-1:0]    new_lvl;
  logic [QUANT_W-1:0]  new_q;
  logic [LIW-1:0]      new_lvl_idx;
  logic                appending;
  logic                ne_bit;
  logic [LIW-1:0]      tail_rd_idx;
  logic [PW-1:0]       tail_rd;
  logic [LEVELS-1:0]   ne_set;
  logic [LEVELS-1:0]   ne_mid;
  logic [LIW-1:0]      pop_lvl_c;
  logic [PW-1:0]       head_mid;

  mfq_ram #(
    .WIDTH(PE_W),
    .DEPTH(MAX_PROCS)
  ) u_proc_ram (
    .clk_i  (clk_i),
    .we_i   (pe_we),
    .waddr_i(pe_waddr),
    .wdata_i(pe_wdata),
    .re_i   (pe_re),
    .raddr_i(pe_raddr),
    .rdata_o(pe_rdata)
  );

  mfq_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_PROCS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (nx_we),
    .waddr_i(nx_waddr),
    .wdata_i(nx_wdata),
    .re_i   (nx_re),
    .raddr_i(nx_raddr),
    .rdata_o(nx_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign res_free   = !out_valid_q || !out_stall_i;

  assign pid_ok  = 32'(in_data_i.process_id) < 32'(MAX_PROCS);
  assign pid_idx = PW'(in_data_i.process_id);

  // A read issued in the same cycle as a write to the same entry picks up
  // the written value here instead of the stale memory word.
  assign pe_cur   = pe_fwd_hit_q ? pe_fwd_data_q : pe_rdata;
  assign nx_cur   = nx_fwd_hit_q ? nx_fwd_data_q : nx_rdata;
  assign queued_r = pe_cur[LVL_W];
  assign lvl_r    = pe_cur[LVL_W-1:0];

  // Slice of the level just read. In the adjust step this is the slice used
  // for the burst test; in the pop step it is the slice reported.
  assign prod_lvl = (BASE_W + 1)'(step_q) * (BASE_W + 1)'(lvl_r);
  assign q_cur    = QUANT_W'(base_q) + QUANT_W'(prod_lvl);

  // burst*5 > q*4 raises the level, burst*2 < q lowers it.
  assign burst_x5 = {1'b0, item_q.last_burst, 2'b00} + (BURST_W + 3)'(item_q.last_burst);
  assign q_x4     = {q_cur, 2'b00};
  assign go_up    = burst_x5 > (BURST_W + 3)'(q_x4);
  assign go_down  = {item_q.last_burst, 1'b0} < (BURST_W + 1)'(q_cur);

  assign first_eff = (item_q.opcode == OP_INSERT) && item_q.first_run;

  // The new slice follows from the old one by adding or taking one step,
  // so no second multiplication sits behind the level decision.
  always_comb begin
    new_lvl = lvl_r;
    new_q   = q_cur;
    if (first_eff) begin
      new_lvl = '0;
      new_q   = QUANT_W'(base_q);
    end else if (go_up) begin
      if (lvl_r < LVL_TOP) begin
        new_lvl = lvl_r + LVL_W'(1);
        new_q   = q_cur + QUANT_W'(step_q);
      end
    end else if (go_down) begin
      if (lvl_r != '0) begin
        new_lvl = lvl_r - LVL_W'(1);
        new_q   = q_cur - QUANT_W'(step_q);
      end
    end
  end

  assign new_lvl_idx = LIW'(new_lvl);
  assign appending   = do_adj_q && !queued_r;
  assign ne_bit      = nonempty_q[new_lvl_idx];

  assign tail_rd_idx = (state_q == ST_POP) ? pop_lvl_q : new_lvl_idx;
  assign tail_rd     = tail_q[tail_rd_idx];

  // Occupancy as it stands once the requeue has appended; the pop of the
  // same dispatch searches this view.
  always_comb begin
    ne_set = '0;
    ne_set[new_lvl_idx] = appending;
  end
  assign ne_mid = nonempty_q | ne_set;

  always_comb begin
    pop_lvl_c = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne_mid[i]) begin
        pop_lvl_c = LIW'(i);
      end
    end
  end

  assign head_mid = (appending && !ne_bit && (pop_lvl_c == new_lvl_idx)) ?
                    adj_proc_q : head_q[pop_lvl_c];

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    base_d      = base_q;
    step_d      = step_q;
    run_proc_d  = run_proc_q;
    run_valid_d = run_valid_q;
    nonempty_d  = nonempty_q;
    out_valid_d = out_valid_q && out_stall_i;
    item_d      = item_q;
    adj_proc_d  = adj_proc_q;
    do_adj_d    = do_adj_q;
    head_d      = head_q;
    tail_d      = tail_q;
    pop_any_d   = pop_any_q;
    pop_lvl_d   = pop_lvl_q;
    pop_proc_d  = pop_proc_q;
    app_d       = app_q;
    out_d       = out_q;
    pe_we       = 1'b0;
    pe_waddr    = '0;
    pe_wdata    = '0;
    pe_re       = 1'b0;
    pe_raddr    = '0;
    nx_we       = 1'b0;
    nx_waddr    = '0;
    nx_wdata    = '0;
    nx_re       = 1'b0;
    nx_raddr    = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_QUANTUM: base_d = cfg_data_i[BASE_W-1:0];
        CFG_QUANTUM_STEP: step_d = cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_CLR: begin
        pe_we     = 1'b1;
        pe_waddr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + PW'(1);
        if (clr_cnt_q == PROC_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          if (in_data_i.opcode == OP_INSERT) begin
            adj_proc_d = pid_idx;
            do_adj_d   = pid_ok;
          end else begin
            adj_proc_d = run_proc_q;
            do_adj_d   = in_data_i.requeue_running && run_valid_q;
          end
          pe_re    = 1'b1;
          pe_raddr = adj_proc_d;
          state_d  = ST_ADJ;
        end
      end

      ST_ADJ: begin
        // An insert ends here and needs the result register; a dispatch
        // moves on to the pop without producing a beat yet.
        if ((item_q.opcode == OP_DISPATCH) || res_free) begin
          if (do_adj_q) begin
            pe_we    = 1'b1;
            pe_waddr = adj_proc_q;
            pe_wdata = {queued_r | appending, new_lvl};
          end
          if (appending) begin
            if (ne_bit) begin
              nx_we    = 1'b1;
              nx_waddr = tail_rd;
              nx_wdata = adj_proc_q;
            end else begin
              head_d[new_lvl_idx]     = adj_proc_q;
              nonempty_d[new_lvl_idx] = 1'b1;
            end
            tail_d[new_lvl_idx] = adj_proc_q;
          end

          if (item_q.opcode == OP_INSERT) begin
            out_valid_d          = 1'b1;
            out_d.dispatched_valid = 1'b0;
            out_d.out_process    = item_q.process_id;
            out_d.out_level      = do_adj_q ? new_lvl : '0;
            out_d.out_quantum    = do_adj_q ? new_q : QUANT_W'(base_q);
            out_d.appended       = appending;
            state_d              = ST_IDLE;
          end else begin
            app_d      = appending;
            pop_any_d  = |ne_mid;
            pop_lvl_d  = pop_lvl_c;
            pop_proc_d = head_mid;
            pe_re      = 1'b1;
            pe_raddr   = head_mid;
            nx_re      = 1'b1;
            nx_raddr   = head_mid;
            state_d    = ST_POP;
          end
        end
      end

      ST_POP: begin
        if (res_free) begin
          out_valid_d = 1'b1;
          run_valid_d = pop_any_q;
          out_d.appended = app_q;
          if (pop_any_q) begin
            pe_we    = 1'b1;
            pe_waddr = pop_proc_q;
            pe_wdata = {1'b0, lvl_r};
            if (tail_rd == pop_proc_q) begin
              nonempty_d[pop_lvl_q] = 1'b0;
            end else begin
              head_d[pop_lvl_q] = nx_cur;
            end
            run_proc_d             = pop_proc_q;
            out_d.dispatched_valid = 1'b1;
            out_d.out_process      = PID_W'(pop_proc_q);
            out_d.out_level        = lvl_r;
            out_d.out_quantum      = q_cur;
          end else begin
            out_d.dispatched_valid = 1'b0;
            out_d.out_process      = '0;
            out_d.out_level        = '0;
            out_d.out_quantum      = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    pe_fwd_hit_d  = pe_fwd_hit_q;
    pe_fwd_data_d = pe_fwd_data_q;
    if (pe_re) begin
      pe_fwd_hit_d  = pe_we && (pe_waddr == pe_raddr);
      pe_fwd_data_d = pe_wdata;
    end
    nx_fwd_hit_d  = nx_fwd_hit_q;
    nx_fwd_data_d = nx_fwd_data_q;
    if (nx_re) begin
      nx_fwd_hit_d  = nx_we && (nx_waddr == nx_raddr);
      nx_fwd_data_d = nx_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      base_q      <= BASE_QUANTUM_RST;
      step_q      <= QUANTUM_STEP_RST;
      run_proc_q  <= '0;
      run_valid_q <= 1'b0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      base_q      <= base_d;
      step_q      <= step_d;
      run_proc_q  <= run_proc_d;
      run_valid_q <= run_valid_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q        <= item_d;
    adj_proc_q    <= adj_proc_d;
    do_adj_q      <= do_adj_d;
    head_q        <= head_d;
    tail_q        <= tail_d;
    pop_any_q     <= pop_any_d;
    pop_lvl_q     <= pop_lvl_d;
    pop_proc_q    <= pop_proc_d;
    app_q         <= app_d;
    out_q         <= out_d;
    pe_fwd_hit_q  <= pe_fwd_hit_d;
    pe_fwd_data_q <= pe_fwd_data_d;
    nx_fwd_hit_q  <= nx_fwd_hit_d;
    nx_fwd_data_q <= nx_fwd_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/mfq_checker.sv
module mfq_checker #(
  parameter int unsigned LEVELS = mfq_pkg::LEVELS_DEFAULT
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input mfq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input mfq_pkg::out_t out_data_o
);

  import mfq_pkg::*;

  // A stalled result beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The block works on one item at a time: it is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while the first is in flight");

  // Reported levels stay inside the configured range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_level <= LVL_W'(LEVELS - 1))
    else $error("reported level beyond the last level");

  // A stalled input beat stays offered and unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

endmodule

bind multilevel_feedback_queue_scheduler_top mfq_checker #(
  .LEVELS(LEVELS)
) u_mfq_checker (.*);

### test/multilevel_feedback_queue_scheduler_top_tb.sv
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler_top_tb;
  import mfq_pkg::*;

  localparam int NPROC = MAX_PROCS_DEFAULT;
  localparam int NLEV  = LEVELS_DEFAULT;
  // Generous bound: every beat waiting out the longest sender gap, the longest
  // receiver stall and the dispatch latency, plus the clearing pass, many times.
  localparam int CYCLE_LIMIT = 600000;

  // One row of the directed table. When typed is set, want holds the result
  // read straight off the scheduler rules; otherwise the predictor decides.
  typedef struct {
    in_t  beat;
    bit   typed;
    out_t want;
  } row_t;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  logic  [CFG_IDX_W-1:0]  cfg_idx_i;
  logic  [CFG_DATA_W-1:0] cfg_data_i;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  multilevel_feedback_queue_scheduler_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the scheduler: slice settings, per-process level and
  // queued mark, the linked FIFOs of every level and the running process.
  logic [BASE_W-1:0]  base_q;
  logic [STEP_W-1:0]  step_q;
  logic [LVL_W-1:0]   proc_level [NPROC];
  bit                 proc_queued [NPROC];
  logic [PID_W-1:0]   link_next [NPROC];
  logic [PID_W-1:0]   lvl_head [NLEV];
  logic [PID_W-1:0]   lvl_tail [NLEV];
  logic [NLEV-1:0]    lvl_busy;
  logic [PID_W-1:0]   cur_proc;
  bit                 cur_valid;

  // Results still owed by the block, oldest first.
  out_t due_q[$];

  row_t directed_rows [26];

  int  errors;
  int  printed;
  int  beats_sent;
  int  results_seen;
  int  picks_seen;
  int  appends_seen;
  int  settings_used;
  int  cycle_count;
  int  hold_left;
  bit  send_calm;
  bit  stall_calm;

  function automatic int unsigned slice_of(int unsigned lvl);
    return base_q + step_q * lvl;
  endfunction

  // Gap length for either side: one draw in ten takes the long range, else the short.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Level feedback followed by the append. The level moves even when the
  // process already sits in a FIFO; it then stays where it was queued.
  function automatic bit ready_proc(logic [PID_W-1:0] p, bit first,
                                    logic [BURST_W-1:0] burst);
    int unsigned lvl;
    int unsigned q;
    lvl = proc_level[p];
    if (first) begin
      lvl = 0;
    end else begin
      q = slice_of(lvl);
      if (32'(burst) * 5 > q * 4) begin
        if (lvl < NLEV - 1) lvl++;
      end else if (32'(burst) * 2 < q) begin
        if (lvl > 0) lvl--;
      end
    end
    proc_level[p] = LVL_W'(lvl);
    if (proc_queued[p]) return 1'b0;
    if (lvl_busy[lvl]) begin
      link_next[lvl_tail[lvl]] = p;
      lvl_tail[lvl] = p;
    end else begin
      lvl_head[lvl] = p;
      lvl_tail[lvl] = p;
      lvl_busy[lvl] = 1'b1;
    end
    proc_queued[p] = 1'b1;
    return 1'b1;
  endfunction

  // Works out the result of one accepted beat and advances the shadow state.
  function automatic out_t schedule_step(in_t beat);
    out_t r;
    logic [PID_W-1:0] p;
    r = '0;
    if (beat.opcode == OP_INSERT) begin
      r.appended    = ready_proc(beat.process_id, beat.first_run, beat.last_burst);
      r.out_process = beat.process_id;
      r.out_level   = proc_level[beat.process_id];
      r.out_quantum = QUANT_W'(slice_of(r.out_level));
    end else begin
      // The running process goes back first, so it may be popped again at once.
      if (beat.requeue_running && cur_valid)
        r.appended = ready_proc(cur_proc, 1'b0, beat.last_burst);
      cur_valid = 1'b0;
      for (int l = 0; l < NLEV; l++) begin
        if (lvl_busy[l]) begin
          p = lvl_head[l];
          if (lvl_head[l] == lvl_tail[l]) lvl_busy[l] = 1'b0;
          else lvl_head[l] = link_next[p];
          proc_queued[p]     = 1'b0;
          cur_proc           = p;
          cur_valid          = 1'b1;
          r.dispatched_valid = 1'b1;
          r.out_process      = p;
          r.out_level        = proc_level[p];
          r.out_quantum      = QUANT_W'(slice_of(proc_level[p]));
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic row_t mk(opcode_e op, int pid, bit first, int burst, bit rq,
                              bit typed, bit v, int p, int lv, int q, bit a);
    row_t r;
    r.beat  = '{op, PID_W'(pid), first, BURST_W'(burst), rq};
    r.typed = typed;
    r.want  = '{v, PID_W'(p), LVL_W'(lv), QUANT_W'(q), a};
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (printed < 40) begin
      printed++;
      $display("mismatch at result %0d: %s got %0d, expected %0d",
               results_seen, what, got, want);
    end
  endtask

  task automatic check_result(out_t got);
    out_t want;
    results_seen++;
    if (due_q.size() == 0) begin
      report_mismatch("result beat with nothing outstanding, process", got.out_process, -1);
      return;
    end
    want = due_q.pop_front();
    if (got.dispatched_valid !== want.dispatched_valid)
      report_mismatch("dispatched_valid", got.dispatched_valid, want.dispatched_valid);
    if (got.out_process !== want.out_process)
      report_mismatch("out_process", got.out_process, want.out_process);
    if (got.out_level !== want.out_level)
      report_mismatch("out_level", got.out_level, want.out_level);
    if (got.out_quantum !== want.out_quantum)
      report_mismatch("out_quantum", got.out_quantum, want.out_quantum);
    if (got.appended !== want.appended)
      report_mismatch("appended", got.appended, want.appended);
    if (want.dispatched_valid) picks_seen++;
    if (want.appended) appends_seen++;
  endtask

  // Result side: a beat moves at an edge where valid is high and our stall is
  // low. Both are sampled before the edge's updates land, so the check never
  // races the block. The stall pattern runs in bursts, except in calm phases.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      check_result(out_data_o);
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!stall_calm && $urandom_range(0, 4) == 0) begin
      hold_left = pick_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, due_q.size());
      $display("[multilevel_feedback_queue_scheduler_top] ERROR");
      $finish;
    end
  end

  // Holds one beat on the input until the block takes it, then records what it
  // must produce. Valid stays up into the next beat unless a gap is drawn.
  task automatic send_beat(in_t beat, bit typed, out_t want);
    out_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = schedule_step(beat);
    due_q.push_back(typed ? want : predicted);
    beats_sent++;
    if (!send_calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every owed result has been taken, so the
  // block is idle. Every beat yields a result, so a short settle is enough.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both slice registers on consecutive edges; the enable drops once.
  task automatic set_slices(int unsigned base, int unsigned step);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BASE_QUANTUM;
    cfg_data_i <= CFG_DATA_W'(base);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_QUANTUM_STEP;
    cfg_data_i <= CFG_DATA_W'(step);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_q = BASE_W'(base);
    step_q = STEP_W'(step);
    settings_used++;
  endtask

  // One random phase under one slice setting. Inserts slightly outnumber
  // dispatches so that the FIFOs stay populated; most pids come from a small
  // hot set so that already-queued inserts and requeues of queued processes
  // happen often. Bursts cluster around the rise and fall thresholds of the
  // process they apply to, so levels really move up and down.
  task automatic run_phase(int unsigned base, int unsigned step, int count,
                           bit calm_in, bit calm_out);
    in_t beat;
    int unsigned q;
    drain();
    set_slices(base, step);
    send_calm  = calm_in;
    stall_calm = calm_out;
    repeat (count) begin
      beat.opcode          = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_DISPATCH;
      beat.process_id      = ($urandom_range(0, 4) < 3) ? PID_W'($urandom_range(0, 7))
                                                        : PID_W'($urandom);
      beat.first_run       = ($urandom_range(0, 9) == 0);
      beat.requeue_running = ($urandom_range(0, 3) != 0);
      q = slice_of(beat.opcode == OP_INSERT ? proc_level[beat.process_id]
                                            : proc_level[cur_proc]);
      case ($urandom_range(0, 9))
        0:       beat.last_burst = '0;
        1:       beat.last_burst = '1;
        2, 3:    beat.last_burst = BURST_W'($urandom);
        4:       beat.last_burst = BURST_W'((q * 4) / 5);
        5:       beat.last_burst = BURST_W'((q * 4) / 5 + 1);
        6:       beat.last_burst = BURST_W'((q - 1) / 2);
        7:       beat.last_burst = BURST_W'((q + 1) / 2);
        default: beat.last_burst = BURST_W'($urandom_range(0, 2 * q));
      endcase
      send_beat(beat, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned ph_base [7];
    int unsigned ph_step [7];
    bit          ph_calm_in [7];
    bit          ph_calm_out [7];

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_BASE_QUANTUM;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;

    base_q    = BASE_QUANTUM_RST;
    step_q    = QUANTUM_STEP_RST;
    lvl_busy  = '0;
    cur_proc  = '0;
    cur_valid = 1'b0;
    for (int i = 0; i < NPROC; i++) begin
      proc_level[i]  = '0;
      proc_queued[i] = 1'b0;
    end

    // Directed part, run with the reset slice settings (base 5, step 3).
    directed_rows[0]  = mk(OP_DISPATCH,  0, 0,     0, 1,  1, 0,  0, 0,  0, 0);
    directed_rows[1]  = mk(OP_INSERT,    0, 1, 65535, 0,  1, 0,  0, 0,  5, 1);
    directed_rows[2]  = mk(OP_INSERT,   63, 0, 65535, 0,  1, 0, 63, 1,  8, 1);
    // Already queued: the level still rises but nothing is appended.
    directed_rows[3]  = mk(OP_INSERT,   63, 0, 65535, 0,  1, 0, 63, 2, 11, 0);
    directed_rows[4]  = mk(OP_INSERT,   42, 0,     0, 0,  1, 0, 42, 0,  5, 1);
    directed_rows[5]  = mk(OP_DISPATCH,  0, 0,     0, 0,  1, 1,  0, 0,  5, 0);
    // Requeue of the running process, with the burst right on the rise edge.
    directed_rows[6]  = mk(OP_DISPATCH,  0, 0,     4, 1,  0, 0,  0, 0,  0, 0);
    // Insert of the process that is running right now.
    directed_rows[7]  = mk(OP_INSERT,   42, 0,     2, 0,  0, 0,  0, 0,  0, 0);
    // Requeue of a running process that is already queued.
    directed_rows[8]  = mk(OP_DISPATCH,  0, 0,     3, 1,  0, 0,  0, 0,  0, 0);
    directed_rows[9]  = mk(OP_DISPATCH,  0, 0,     0, 0,  0, 0,  0, 0,  0, 0);
    // Level 0 is empty now; the pop comes from level 1.
    directed_rows[10] = mk(OP_DISPATCH,  0, 0,     0, 0,  0, 0,  0, 0,  0, 0);
    directed_rows[11] = mk(OP_DISPATCH,  0, 0, 65535, 1,  0, 0,  0, 0,  0, 0);
    // All FIFOs empty; the running process is dropped.
    directed_rows[12] = mk(OP_DISPATCH,  0, 0,     0, 0,  1, 0,  0, 0,  0, 0);
    // Requeue asked with nothing running.
    directed_rows[13] = mk(OP_DISPATCH,  0, 0, 65535, 1,  1, 0,  0, 0,  0, 0);
    // Drive one process from level 0 up to the top level and hold it there.
    for (int i = 14; i < 23; i++)
      directed_rows[i] = mk(OP_INSERT,   5, 0, 65535, 0,  0, 0,  0, 0,  0, 0);
    directed_rows[23] = mk(OP_INSERT,    5, 0, 65535, 0,  1, 0,  5, 9, 32, 0);
    // First run pulls the level back to 0 while the process stays queued.
    directed_rows[24] = mk(OP_INSERT,    5, 1, 65535, 0,  1, 0,  5, 0,  5, 0);
    directed_rows[25] = mk(OP_DISPATCH,  0, 0,     0, 0,  0, 0,  0, 0,  0, 0);

    // Slice settings of the random phases: reset values, both extremes, the
    // mixed corners, one random setting and one ordinary one. Some phases run
    // one side or the other without idling.
    ph_base = '{5, 1, 255, 1, 255, 0, 20};
    ph_step = '{3, 0, 31, 31, 0, 0, 7};
    ph_base[5] = $urandom_range(1, 255);
    ph_step[5] = $urandom_range(0, 31);
    ph_calm_in  = '{0, 0, 1, 0, 1, 0, 0};
    ph_calm_out = '{0, 0, 0, 1, 1, 0, 0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first beat waits out the clearing pass on in_stall_o by itself.
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < 7; ph++)
      run_phase(ph_base[ph], ph_step[ph], 200, ph_calm_in[ph], ph_calm_out[ph]);

    send_calm = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d input beats (%0d directed) under %0d slice settings.",
             beats_sent, 26, settings_used);
    $display("Checked %0d result beats: %0d dispatches picked a process, %0d appends.",
             results_seen, picks_seen, appends_seen);
    if (errors == 0 && due_q.size() == 0) begin
      $display("[multilevel_feedback_queue_scheduler_top] OK");
    end else begin
      $display("[multilevel_feedback_queue_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule
